// ----- design/bwrs2_pkg.sv -----
// ----------------------------------------------------------------------------
// bwrs2_pkg: shared types and constants of the 2x Butterworth resampler
// Control-word layout, microcode ROM, fixed Q0.30 filter coefficients.
// ----------------------------------------------------------------------------
package bwrs2_pkg;

  // Default delay-line word width (Q24.16 at 40 bits)
  localparam int STATE_WIDTH_DEF = 40;

  // Signed coefficient width (all coefficients positive, below 2^29)
  localparam int COEF_W = 30;

  // Step counter
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] EMIT_STEP = 4'd12;

  // Rounding constants
  localparam logic [29:0] Q30_HALF   = 30'h2000_0000;
  localparam logic [15:0] ROUND_HALF = 16'h8000;

  // Q0.30 coefficients
  localparam logic signed [COEF_W-1:0] K_GAIN = 30'sd72482734;
  localparam logic signed [COEF_W-1:0] K_A11  = 30'sd484696013;
  localparam logic signed [COEF_W-1:0] K_A12  = 30'sd243793388;
  localparam logic signed [COEF_W-1:0] K_A21  = 30'sd49122482;
  localparam logic signed [COEF_W-1:0] K_A22  = 30'sd175654677;

  // Item operation carried in tuser
  localparam logic OP_DECIMATE = 1'b0;
  localparam logic OP_INTERP   = 1'b1;

  typedef enum logic [2:0] {
    SRC_X  = 3'd0,
    SRC_D0 = 3'd1,
    SRC_D1 = 3'd2,
    SRC_D2 = 3'd3,
    SRC_D3 = 3'd4
  } src_e;

  typedef enum logic {
    HALF_LO = 1'b0,
    HALF_HI = 1'b1
  } half_e;

  typedef enum logic [2:0] {
    COEF_GAIN = 3'd0,
    COEF_A11  = 3'd1,
    COEF_A12  = 3'd2,
    COEF_A21  = 3'd3,
    COEF_A22  = 3'd4
  } coef_e;

  typedef enum logic [2:0] {
    ACC_NOP  = 3'd0,
    ACC_LOAD = 3'd1,
    ACC_ADD  = 3'd2,
    ACC_SUB  = 3'd3,
    ACC_Y1   = 3'd4,
    ACC_Y2   = 3'd5
  } acc_e;

  typedef enum logic {
    FLOW_NEXT = 1'b0,
    FLOW_EMIT = 1'b1
  } flow_e;

  // One microcode word
  typedef struct packed {
    logic  mul_en;
    src_e  src;
    half_e half;
    coef_e coef;
    logic  frac_en;
    acc_e  acc_op;
    flow_e flow;
  } ucode_t;

  // Control bundle from sequencer to datapath
  typedef struct packed {
    ucode_t uw;
    logic   bank;
  } ctrl_t;

  localparam ucode_t UCODE_NOP = '{
    mul_en: 1'b0, src: SRC_X, half: HALF_LO, coef: COEF_GAIN,
    frac_en: 1'b0, acc_op: ACC_NOP, flow: FLOW_NEXT
  };

  function automatic logic signed [COEF_W-1:0] coef_value(coef_e c);
    logic signed [COEF_W-1:0] v;
    unique case (c)
      COEF_GAIN: v = K_GAIN;
      COEF_A11:  v = K_A11;
      COEF_A12:  v = K_A12;
      COEF_A21:  v = K_A21;
      COEF_A22:  v = K_A22;
      default:   v = '0;
    endcase
    return v;
  endfunction

  // Program for one sample through both biquads. Each product takes a low
  // half multiply (rounded into frac) and a high half multiply; the high
  // product plus frac is accumulated in the step after.
  function automatic ucode_t ucode(logic [STEP_W-1:0] step);
    ucode_t w;
    w = UCODE_NOP;
    unique case (step)
      4'd0: begin
        w.mul_en = 1'b1; w.src = SRC_X; w.half = HALF_LO; w.coef = COEF_GAIN;
      end
      4'd1: begin
        w.frac_en = 1'b1;
        w.mul_en = 1'b1; w.src = SRC_X; w.half = HALF_HI; w.coef = COEF_GAIN;
      end
      4'd2: begin
        w.acc_op = ACC_LOAD;
        w.mul_en = 1'b1; w.src = SRC_D0; w.half = HALF_LO; w.coef = COEF_A11;
      end
      4'd3: begin
        w.frac_en = 1'b1;
        w.mul_en = 1'b1; w.src = SRC_D0; w.half = HALF_HI; w.coef = COEF_A11;
      end
      4'd4: begin
        w.acc_op = ACC_SUB;
        w.mul_en = 1'b1; w.src = SRC_D1; w.half = HALF_LO; w.coef = COEF_A12;
      end
      4'd5: begin
        w.frac_en = 1'b1;
        w.mul_en = 1'b1; w.src = SRC_D1; w.half = HALF_HI; w.coef = COEF_A12;
      end
      4'd6: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.src = SRC_D2; w.half = HALF_LO; w.coef = COEF_A21;
      end
      4'd7: begin
        w.frac_en = 1'b1; w.acc_op = ACC_Y1;
        w.mul_en = 1'b1; w.src = SRC_D2; w.half = HALF_HI; w.coef = COEF_A21;
      end
      4'd8: begin
        w.acc_op = ACC_SUB;
        w.mul_en = 1'b1; w.src = SRC_D3; w.half = HALF_LO; w.coef = COEF_A22;
      end
      4'd9: begin
        w.frac_en = 1'b1;
        w.mul_en = 1'b1; w.src = SRC_D3; w.half = HALF_HI; w.coef = COEF_A22;
      end
      4'd10: w.acc_op = ACC_ADD;
      4'd11: w.acc_op = ACC_Y2;
      EMIT_STEP: w.flow = FLOW_EMIT;
      default: w.flow = FLOW_EMIT;
    endcase
    return w;
  endfunction

endpackage

// ----- design/bwrs2_datapath.sv -----
// ----------------------------------------------------------------------------
// bwrs2_datapath: shared multiplier, accumulator and delay banks
// Executes one control word a cycle; holds both filters' delay lines.
// ----------------------------------------------------------------------------
module bwrs2_datapath #(
  parameter int STATE_WIDTH = bwrs2_pkg::STATE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bwrs2_pkg::ctrl_t  ctrl_i,
  input  logic signed [15:0] x_i,
  output logic signed [15:0] sample_o
);

  localparam int SW    = STATE_WIDTH;
  localparam int ACC_W = (SW + 3 > 64) ? 64 : SW + 3;
  localparam int MA    = (SW - 30 > 31) ? SW - 30 : 31;
  localparam int PW    = MA + bwrs2_pkg::COEF_W;

  logic signed [SW-1:0]    dly_q [2][4];
  logic signed [SW-1:0]    d [4];
  logic signed [SW-1:0]    opnd;
  logic signed [31:0]      x16;
  logic signed [MA-1:0]    mul_a;
  logic signed [bwrs2_pkg::COEF_W-1:0] mul_b;
  logic signed [PW-1:0]    prod_d, prod_q;
  logic signed [PW-1:0]    rnd_sum;
  logic [28:0]             frac_q;
  logic signed [ACC_W-1:0] term, acc_d, acc_q, y_val;
  logic signed [SW-1:0]    w_sat;
  logic                    fits;
  logic [ACC_W-1:0]        t, mag, qn, qp;

  // Current bank
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d[i] = dly_q[ctrl_i.bank][i];
    end
  end

  // Multiplier operand select and split
  assign x16 = {x_i, 16'h0000};

  always_comb begin
    case (ctrl_i.uw.src)
      bwrs2_pkg::SRC_X:  opnd = SW'(x16);
      bwrs2_pkg::SRC_D0: opnd = d[0];
      bwrs2_pkg::SRC_D1: opnd = d[1];
      bwrs2_pkg::SRC_D2: opnd = d[2];
      bwrs2_pkg::SRC_D3: opnd = d[3];
      default:           opnd = '0;
    endcase
  end

  assign mul_a = (ctrl_i.uw.half == bwrs2_pkg::HALF_HI) ?
                 MA'(signed'(opnd[SW-1:30])) : MA'({1'b0, opnd[29:0]});
  assign mul_b  = bwrs2_pkg::coef_value(ctrl_i.uw.coef);
  assign prod_d = mul_a * mul_b;

  // Rounded fraction of the low-half product
  assign rnd_sum = prod_q + PW'({1'b0, bwrs2_pkg::Q30_HALF});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.uw.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.uw.frac_en) begin
      frac_q <= rnd_sum[58:30];
    end
  end

  // Term = high product + rounded low fraction
  assign term = ACC_W'(prod_q) + {{(ACC_W-29){1'b0}}, frac_q};

  // Saturate accumulator to state range
  assign fits  = (&acc_q[ACC_W-1:SW-1]) | ~(|acc_q[ACC_W-1:SW-1]);
  assign w_sat = fits ? acc_q[SW-1:0] :
                 (acc_q[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

  // Biquad output y = older + 2*newer + w
  always_comb begin
    if (ctrl_i.uw.acc_op == bwrs2_pkg::ACC_Y2) begin
      y_val = ACC_W'(d[2]) + ACC_W'(d[3]) + ACC_W'(d[3]) + ACC_W'(w_sat);
    end else begin
      y_val = ACC_W'(d[0]) + ACC_W'(d[1]) + ACC_W'(d[1]) + ACC_W'(w_sat);
    end
  end

  always_comb begin
    case (ctrl_i.uw.acc_op) inside
      bwrs2_pkg::ACC_LOAD: acc_d = term;
      bwrs2_pkg::ACC_ADD:  acc_d = acc_q + term;
      bwrs2_pkg::ACC_SUB:  acc_d = acc_q - term;
      bwrs2_pkg::ACC_Y1,
      bwrs2_pkg::ACC_Y2:   acc_d = y_val;
      default:             acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Delay line shift on each biquad's update step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 4; i++) begin
          dly_q[b][i] <= '0;
        end
      end
    end else if (ctrl_i.uw.acc_op == bwrs2_pkg::ACC_Y1) begin
      dly_q[ctrl_i.bank][0] <= d[1];
      dly_q[ctrl_i.bank][1] <= w_sat;
    end else if (ctrl_i.uw.acc_op == bwrs2_pkg::ACC_Y2) begin
      dly_q[ctrl_i.bank][2] <= d[3];
      dly_q[ctrl_i.bank][3] <= w_sat;
    end
  end

  // Output conversion: add half, truncate toward zero, saturate
  assign t   = acc_q + ACC_W'(bwrs2_pkg::ROUND_HALF);
  assign mag = ACC_W'(0) - t;
  assign qn  = mag >> 16;
  assign qp  = t >> 16;

  always_comb begin
    if (t[ACC_W-1]) begin
      if (qn > ACC_W'(32'd32768)) begin
        sample_o = 16'sh8000;
      end else begin
        sample_o = 16'h0000 - qn[15:0];
      end
    end else begin
      if (qp > ACC_W'(32'd32767)) begin
        sample_o = 16'sh7FFF;
      end else begin
        sample_o = qp[15:0];
      end
    end
  end

`ifndef ASSERT_OFF
  // First biquad update shifts the newer delay into the older slot
  a_y1_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.uw.acc_op == bwrs2_pkg::ACC_Y1 |=>
      dly_q[$past(ctrl_i.bank)][0] == $past(dly_q[ctrl_i.bank][1]))
    else $error("first biquad delay shift lost");

  // First biquad update stores the saturated new delay
  a_y1_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.uw.acc_op == bwrs2_pkg::ACC_Y1 |=>
      dly_q[$past(ctrl_i.bank)][1] == $past(w_sat))
    else $error("first biquad new delay not stored");

  // Second biquad update shifts the newer delay into the older slot
  a_y2_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.uw.acc_op == bwrs2_pkg::ACC_Y2 |=>
      dly_q[$past(ctrl_i.bank)][2] == $past(dly_q[ctrl_i.bank][3]))
    else $error("second biquad delay shift lost");
`endif

endmodule

// ----- design/butterworth_resample_by_two.sv -----
// ----------------------------------------------------------------------------
// butterworth_resample_by_two: 2x resampler on a 4th-order Butterworth filter
// Microcoded sequencer driving one shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// Each filter pass runs 12 microcode steps of the shared multiplier,
// 10 multiplies, then an emit step; an item runs two passes. A new
// item is accepted only once both passes of the last one are done.
// The first result enters the output register at the first emit step.
// An emitting step waits while the output register is full and unread.
// Reset clears both delay banks, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module butterworth_resample_by_two #(
  parameter int STATE_WIDTH = bwrs2_pkg::STATE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] first_sample, [31:16] second_sample
  input  logic [0:0]  s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_sample
  output logic        m_axis_tlast
);

  logic                          busy_q, busy_d;
  logic                          pass_q, pass_d;
  logic [bwrs2_pkg::STEP_W-1:0]  upc_q, upc_d;
  logic                          op_q, op_d;
  logic signed [15:0]            x_q, x_d;
  logic signed [15:0]            second_q, second_d;
  logic                          out_valid_q, out_valid_d;
  logic [15:0]                   out_data_q;
  logic                          out_last_q;
  logic signed [15:0]            sample;
  bwrs2_pkg::ucode_t             uw;
  bwrs2_pkg::ctrl_t              ctrl;
  logic                          in_xfer, emit_need, stall, out_load;

  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~busy_q;

  // Microcode fetch
  assign uw        = bwrs2_pkg::ucode(upc_q);
  assign ctrl.uw   = busy_q ? uw : bwrs2_pkg::UCODE_NOP;
  assign ctrl.bank = op_q;

  // Decimate emits only at the end of its first pass
  assign emit_need = (op_q == bwrs2_pkg::OP_INTERP) | ~pass_q;
  assign stall     = emit_need & out_valid_q & ~m_axis_tready;
  assign out_load  = busy_q & (uw.flow == bwrs2_pkg::FLOW_EMIT) & emit_need & ~stall;

  // Sequencer
  always_comb begin
    busy_d   = busy_q;
    pass_d   = pass_q;
    upc_d    = upc_q;
    op_d     = op_q;
    x_d      = x_q;
    second_d = second_q;
    if (in_xfer) begin
      busy_d   = 1'b1;
      pass_d   = 1'b0;
      upc_d    = '0;
      op_d     = s_axis_tuser[0];
      x_d      = s_axis_tdata[15:0];
      second_d = s_axis_tdata[31:16];
    end else if (busy_q) begin
      if (uw.flow == bwrs2_pkg::FLOW_NEXT) begin
        upc_d = upc_q + 1'b1;
      end else if (!stall) begin
        upc_d = '0;
        if (pass_q) begin
          busy_d = 1'b0;
        end else begin
          pass_d = 1'b1;
          x_d    = (op_q == bwrs2_pkg::OP_INTERP) ? 16'sd0 : second_q;
        end
      end
    end
  end

  // Output register
  assign out_valid_d = out_load | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pass_q      <= 1'b0;
      upc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pass_q      <= pass_d;
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    x_q      <= x_d;
    second_q <= second_d;
    if (out_load) begin
      out_data_q <= sample;
      out_last_q <= (op_q == bwrs2_pkg::OP_DECIMATE) | pass_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  bwrs2_datapath #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .x_i     (x_q),
    .sample_o(sample)
  );

`ifndef ASSERT_OFF
  // A transfer starts the program at its first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q && upc_q == '0 && !pass_q)
    else $error("item did not start at step zero");

  // A stalled emit step holds its place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && uw.flow == bwrs2_pkg::FLOW_EMIT && stall |=>
      busy_q && upc_q == $past(upc_q) && pass_q == $past(pass_q))
    else $error("emit step moved on while output full");

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || m_axis_tready)
    else $error("output register overwritten");
`endif

endmodule
